[rtl/pressure_sensor_compensation_defines.svh]
// assertion macros shared by the compensation block
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

// checked only out of reset
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psc_pkg.sv]
// shared types and constants of the pressure sensor compensation block
package psc_pkg;

  typedef enum logic [2:0] {
    REG_SENS       = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_SENS_TEMP  = 3'd2,
    REG_OFFS_TEMP  = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_SLOPE = 3'd5,
    REG_DENSITY    = 3'd6,
    REG_DEPTH_OFS  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        sens_coef;
    logic [15:0]        offset_coef;
    logic [15:0]        sens_temp_coef;
    logic [15:0]        offset_temp_coef;
    logic [15:0]        ref_temp_coef;
    logic [15:0]        temp_slope_coef;
    logic [11:0]        fluid_density_kgm3;
    logic signed [17:0] depth_offset_mm;
  } cfg_t;

  // front pipeline result handed from front to back
  typedef struct packed {
    logic signed [18:0] temp;
    logic signed [41:0] off;
    logic signed [41:0] sens;
    logic [23:0]        raw_pressure;
  } item_t;

  localparam logic [11:0] DEFAULT_DENSITY = 12'd1000;
  localparam logic [31:0] GRAVITY_E5      = 32'd980665;
  localparam int          TEMP_REF        = 2000;
  localparam int          TEMP_VLOW       = -1500;
  localparam int          TEMP_MAX        = 262143;
  localparam int          TEMP_MIN        = -262144;

  // quotient bits of the depth divider and steps per cycle
  localparam int QUOT_W    = 45;
  localparam int DIV_STEPS = 3;
  localparam int DIV_CYC   = QUOT_W / DIV_STEPS;

endpackage

[rtl/psc_front.sv]
// front pipeline: temperature, offset and sensitivity with second order correction
module psc_front (
  input  logic              clk,
  input  logic              rst,
  input  psc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [23:0]       raw_temperature,
  input  logic [23:0]       raw_pressure,
  output logic              push,
  input  logic              q_full,
  output psc_pkg::item_t    push_item
);
  import psc_pkg::*;

  typedef enum logic [1:0] {
    T_HIGH,
    T_LOW,
    T_VLOW
  } tclass_t;

  logic adv;
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic signed [24:0] dt1;
  logic [23:0]        d1_1;
  // stage 2
  logic signed [41:0] m_t, m_off, m_sens;
  logic signed [49:0] m_dd;
  logic [23:0]        d1_2;
  // stage 3
  logic signed [17:0] dtemp3;
  logic signed [18:0] temp3;
  logic signed [41:0] off3, sens3;
  logic [16:0]        t2lo3;
  logic [13:0]        t2hi3;
  logic [23:0]        d1_3;
  // stage 4
  tclass_t            cls4;
  logic signed [35:0] sqd4;
  logic signed [39:0] sql4;
  logic [16:0]        t2_4;
  logic signed [18:0] temp4;
  logic signed [41:0] off4, sens4;
  logic [23:0]        d1_4;
  // stage 5
  item_t              item5;

  logic signed [24:0] dt_c;
  logic signed [41:0] q_t;
  logic [49:0]        dd_u;
  logic [50:0]        dd3;
  logic signed [19:0] lo_c;
  logic [41:0]        sqd_u, sql_u, off2, sens2;
  logic signed [19:0] tt;
  item_t              item_c;

  assign adv      = !(v5 && q_full);
  assign in_ready = adv;
  assign push     = v5 && !q_full;
  assign push_item = item5;

  always_comb begin
    dt_c  = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp_coef, 8'd0});
    q_t   = m_t / 42'sd8388608;
    dd_u  = m_dd;
    dd3   = 51'(dd_u) + {dd_u, 1'b0};
    lo_c  = 20'(temp3) - 20'(TEMP_VLOW);
    sqd_u = {6'd0, sqd4};
    sql_u = {2'd0, sql4};
    off2  = '0;
    sens2 = '0;
    case (cls4)
      T_HIGH: begin
        off2 = sqd_u >> 4;
      end
      T_LOW: begin
        off2  = (sqd_u + {sqd_u[40:0], 1'b0}) >> 1;
        sens2 = (sqd_u + {sqd_u[39:0], 2'd0}) >> 3;
      end
      T_VLOW: begin
        off2  = ((sqd_u + {sqd_u[40:0], 1'b0}) >> 1) + ({sql_u[38:0], 3'd0} - sql_u);
        sens2 = ((sqd_u + {sqd_u[39:0], 2'd0}) >> 3) + {sql_u[39:0], 2'd0};
      end
      default: begin
        off2 = '0;
      end
    endcase
    tt = 20'(temp4) - $signed({3'd0, t2_4});
    item_c.raw_pressure = d1_4;
    item_c.off  = off4 - $signed(off2);
    item_c.sens = sens4 - $signed(sens2);
    if (tt < 20'(TEMP_MIN))      item_c.temp = 19'(TEMP_MIN);
    else if (tt > 20'(TEMP_MAX)) item_c.temp = 19'(TEMP_MAX);
    else                         item_c.temp = tt[18:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt1    <= dt_c;
      d1_1   <= raw_pressure;

      m_t    <= dt1 * $signed({1'b0, cfg.temp_slope_coef});
      m_off  <= dt1 * $signed({1'b0, cfg.offset_temp_coef});
      m_sens <= dt1 * $signed({1'b0, cfg.sens_temp_coef});
      m_dd   <= dt1 * dt1;
      d1_2   <= d1_1;

      dtemp3 <= q_t[17:0];
      temp3  <= 19'(q_t) + 19'(TEMP_REF);
      off3   <= 42'($signed({1'b0, cfg.offset_coef, 16'd0})) + m_off / 42'sd128;
      sens3  <= 42'($signed({1'b0, cfg.sens_coef, 15'd0})) + m_sens / 42'sd256;
      t2lo3  <= dd3[49:33];
      t2hi3  <= dd_u[49:36];
      d1_3   <= d1_2;

      if (temp3 >= 19'(TEMP_REF))      cls4 <= T_HIGH;
      else if (temp3 < 19'(TEMP_VLOW)) cls4 <= T_VLOW;
      else                             cls4 <= T_LOW;
      sqd4  <= dtemp3 * dtemp3;
      sql4  <= lo_c * lo_c;
      t2_4  <= (temp3 < 19'(TEMP_REF)) ? t2lo3 : {3'd0, t2hi3};
      temp4 <= temp3;
      off4  <= off3;
      sens4 <= sens3;
      d1_4  <= d1_3;

      item5 <= item_c;
    end
  end

endmodule

[rtl/psc_queue.sv]
// two entry queue between front and back
`include "pressure_sensor_compensation_defines.svh"

module psc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output psc_pkg::item_t pop_item
);
  import psc_pkg::*;

  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `PSC_ASSERT(a_q_count_max, count != 2'd3, "queue count out of range")
  `PSC_ASSERT(a_q_no_overflow, full |-> !push, "push into full queue")
  `PSC_ASSERT(a_q_no_underflow, empty |-> !pop, "pop from empty queue")

endmodule

[rtl/psc_back.sv]
// back end: pressure, depth division and output register
`include "pressure_sensor_compensation_defines.svh"

module psc_back (
  input  logic           clk,
  input  logic           rst,
  input  psc_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  psc_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [18:0]    out_temp,
  output logic [31:0]    out_pressure,
  output logic [31:0]    out_depth
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_PRES,
    S_SCALE,
    S_ABS,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state;
  item_t              it;
  logic [44:0]        pl;
  logic signed [45:0] ph;
  logic signed [45:0] a_r;
  logic signed [31:0] p_r;
  logic signed [61:0] pm;
  logic [31:0]        dvs;
  logic               neg;
  logic [31:0]        rem;
  logic [QUOT_W-1:0]  nq;
  logic [3:0]         div_cnt;

  logic signed [66:0] prod;
  logic signed [66:0] a_c;
  logic signed [46:0] diff;
  logic signed [46:0] p_c;
  logic [11:0]        rho;
  logic [61:0]        mag;
  logic [32:0]        r;
  logic [QUOT_W-1:0]  nq_c;
  logic signed [46:0] qs;
  logic signed [47:0] dep;
  logic [31:0]        dep_sat;

  assign pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    prod = (67'(ph) <<< 21) + $signed({22'd0, pl});
    a_c  = prod / 67'sd2097152;
    diff = 47'(a_r) - 47'(it.off);
    p_c  = diff / 47'sd8192;
    rho  = (cfg.fluid_density_kgm3 == 12'd0) ? DEFAULT_DENSITY : cfg.fluid_density_kgm3;
    mag  = pm[61] ? 62'(-pm) : 62'(pm);
    r    = {1'b0, rem};
    nq_c = nq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r    = {r[31:0], nq_c[QUOT_W-1]};
      nq_c = {nq_c[QUOT_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r       = r - {1'b0, dvs};
        nq_c[0] = 1'b1;
      end
    end
    qs  = neg ? -47'(nq) : 47'(nq);
    dep = 48'(qs) - 48'(cfg.depth_offset_mm);
    if (dep < -48'sd2147483648)     dep_sat = 32'h8000_0000;
    else if (dep > 48'sd2147483647) dep_sat = 32'h7FFF_FFFF;
    else                            dep_sat = dep[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            it    <= q_item;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pl    <= it.raw_pressure * it.sens[20:0];
          ph    <= $signed({1'b0, it.raw_pressure}) * $signed(it.sens[41:21]);
          state <= S_SUM;
        end
        S_SUM: begin
          a_r   <= a_c[45:0];
          state <= S_PRES;
        end
        S_PRES: begin
          if (p_c < -47'sd2147483648)     p_r <= 32'sh8000_0000;
          else if (p_c > 47'sd2147483647) p_r <= 32'sh7FFF_FFFF;
          else                            p_r <= p_c[31:0];
          state <= S_SCALE;
        end
        S_SCALE: begin
          pm    <= 62'(p_r) * 62'sd1000000000;
          dvs   <= 32'(rho) * GRAVITY_E5;
          state <= S_ABS;
        end
        S_ABS: begin
          neg     <= pm[61];
          rem     <= 32'(mag[61:QUOT_W]);
          nq      <= mag[QUOT_W-1:0];
          div_cnt <= 4'(DIV_CYC - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= r[31:0];
          nq      <= nq_c;
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == 4'd0) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_temp     <= it.temp;
            out_pressure <= p_r;
            out_depth    <= dep_sat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSC_ASSERT(a_b_div_start, state == S_ABS |=> state == S_DIV && div_cnt == 4'(DIV_CYC - 1),
    "divider not started with full count")
  `PSC_ASSERT(a_b_div_end, state == S_DIV && div_cnt == 4'd0 |=> state == S_DONE,
    "divider did not finish")
  `PSC_ASSERT(a_b_hold, state == S_DONE && out_valid && !out_ready |=> state == S_DONE,
    "result dropped while output busy")

endmodule

[rtl/pressure_sensor_compensation.sv]
// top level: configuration registers, front pipeline, queue and back end
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   raw_temperature, raw_pressure
//   m_axis    out  m_axis_tvalid/m_axis_tready   temperature, pressure, depth
//   cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// the front is a five stage pipeline and takes one request a cycle until the
// two entry queue fills; the back works on one request at a time through its
// sequencer and radix-8 depth divider and pops the next only when idle
// reset is synchronous and clears valids, queue and sequencer; coefficients
// return to zero, density to 1000 and depth offset to zero
// the output register lets the back finish its next request while a result waits
module pressure_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_temperature[23:0], raw_pressure[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // temperature_centi_c[18:0], pressure_decimbar[50:19],
                                      // depth_mm[82:51], zero[87:83]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import psc_pkg::*;

  cfg_t        cfg;
  logic        push, q_full, q_empty, pop;
  item_t       push_item, pop_item;
  logic [18:0] out_temp;
  logic [31:0] out_pressure, out_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sens_coef          <= '0;
      cfg.offset_coef        <= '0;
      cfg.sens_temp_coef     <= '0;
      cfg.offset_temp_coef   <= '0;
      cfg.ref_temp_coef      <= '0;
      cfg.temp_slope_coef    <= '0;
      cfg.fluid_density_kgm3 <= DEFAULT_DENSITY;
      cfg.depth_offset_mm    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENS:       cfg.sens_coef          <= cfg_data[15:0];
        REG_OFFSET:     cfg.offset_coef        <= cfg_data[15:0];
        REG_SENS_TEMP:  cfg.sens_temp_coef     <= cfg_data[15:0];
        REG_OFFS_TEMP:  cfg.offset_temp_coef   <= cfg_data[15:0];
        REG_REF_TEMP:   cfg.ref_temp_coef      <= cfg_data[15:0];
        REG_TEMP_SLOPE: cfg.temp_slope_coef    <= cfg_data[15:0];
        REG_DENSITY:    cfg.fluid_density_kgm3 <= cfg_data[11:0];
        REG_DEPTH_OFS:  cfg.depth_offset_mm    <= $signed(cfg_data);
        default:        cfg.sens_coef          <= cfg.sens_coef;
      endcase
    end
  end

  psc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .raw_temperature (s_axis_tdata[23:0]),
    .raw_pressure    (s_axis_tdata[47:24]),
    .push            (push),
    .q_full          (q_full),
    .push_item       (push_item)
  );

  psc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  psc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_temp     (out_temp),
    .out_pressure (out_pressure),
    .out_depth    (out_depth)
  );

  assign m_axis_tdata = {5'd0, out_depth, out_pressure, out_temp};

endmodule
